>>> rtl/core/rvb_pkg.sv
// Shared constants, types and helper functions for the stereo reverb unit.
// Used by the controller, datapath and top-level files; no dependencies.
`timescale 1ns / 1ps
package rvb_pkg;

  localparam int NUM_COMBS     = 8;
  localparam int NUM_ALLPASS   = 4;
  localparam int COMB_DEPTH    = 2048;
  localparam int ALLPASS_DEPTH = 1024;
  localparam int TANH_ENTRIES  = 256;

  localparam int SAMPLE_W  = 24;
  localparam int DATA_W    = 2 * SAMPLE_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int COMB_PW  = $clog2(COMB_DEPTH);
  localparam int AP_PW    = $clog2(ALLPASS_DEPTH);
  localparam int COMB_IW  = $clog2(NUM_COMBS);
  localparam int AP_IW    = $clog2(NUM_ALLPASS);
  localparam int COMB_AW  = $clog2(NUM_COMBS * COMB_DEPTH);
  localparam int AP_AW    = $clog2(NUM_ALLPASS * ALLPASS_DEPTH);
  localparam int CLR_AW   = (COMB_AW > AP_AW) ? COMB_AW : AP_AW;
  localparam int MAX_UNITS = (NUM_COMBS > NUM_ALLPASS) ? NUM_COMBS : NUM_ALLPASS;
  localparam int UNIT_W   = $clog2(MAX_UNITS);

  localparam int SUM_W     = SAMPLE_W + COMB_IW + 3;
  localparam int SUM_SHIFT = $clog2(2 * NUM_COMBS);
  localparam int PROD_W    = 42;
  localparam int WIDE_W    = 48;
  localparam int MIX_W     = 26;
  localparam int TANH_IW   = $clog2(TANH_ENTRIES + 1);
  localparam int FRAC_W    = 25 - $clog2(TANH_ENTRIES);
  localparam int INTERP_W  = SAMPLE_W + FRAC_W + 2;

  localparam logic [14:0] FEEDBACK_RESET = 15'd27525;
  localparam logic [14:0] DAMPING_RESET  = 15'd6554;
  localparam logic [15:0] DRY_RESET      = 16'd32768;
  localparam logic [15:0] WET_RESET      = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEEDBACK = 2'd0,
    CFG_DAMPING  = 2'd1,
    CFG_DRY      = 2'd2,
    CFG_WET      = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_COMB_RD, ST_COMB_MUL, ST_COMB_LP, ST_COMB_FB, ST_COMB_WR,
    ST_SUM, ST_AP_RD, ST_AP_UPD, ST_MIX_MUL, ST_MIX_SUM, ST_TAB0, ST_TAB1,
    ST_INTERP, ST_EMIT
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_COMB_RD, OP_COMB_MUL, OP_COMB_LP, OP_COMB_FB,
    OP_COMB_WR, OP_SUM, OP_AP_RD, OP_AP_UPD, OP_MIX_MUL, OP_MIX_SUM, OP_TAB0,
    OP_TAB1, OP_INTERP, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [UNIT_W-1:0]   unit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

  typedef logic [SAMPLE_W-1:0] tanh_tab_t [TANH_ENTRIES+1];

  function automatic logic [COMB_PW:0] comb_len(input int i);
    int l;
    case (i & 7)
      0: l = 1116;
      1: l = 1188;
      2: l = 1277;
      3: l = 1356;
      4: l = 1422;
      5: l = 1491;
      6: l = 1557;
      default: l = 1617;
    endcase
    if (l > COMB_DEPTH) l = COMB_DEPTH;
    return (COMB_PW+1)'(l);
  endfunction

  function automatic logic [AP_PW:0] ap_len(input int i);
    int l;
    case (i & 3)
      0: l = 556;
      1: l = 441;
      2: l = 341;
      default: l = 225;
    endcase
    if (l > ALLPASS_DEPTH) l = ALLPASS_DEPTH;
    return (AP_PW+1)'(l);
  endfunction

  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry i holds tanh(4*i/TANH_ENTRIES) in Q1.23, built from a Taylor series for exp.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t         tab;
    longint unsigned   one;
    longint unsigned   y;
    longint unsigned   e;
    longint unsigned   term;
    longint unsigned   q;
    one = 64'd1 << 24;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      y    = (64'(i) << 27) / TANH_ENTRIES;
      e    = one;
      term = one;
      for (int k = 1; k < 80; k++) begin
        if (term != 0) begin
          term = udiv64((term * y) >> 24, 64'(k));
          e    = e + term;
        end
      end
      q      = udiv64(((e - one) << 23) + ((e + one) >> 1), e + one);
      tab[i] = q[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(signed'(24'sh7FFFFF))) return 24'sh7FFFFF;
    if (v < WIDE_W'(signed'(24'sh800000))) return 24'sh800000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(signed'(26'sh1FFFFFF))) return 26'sh1FFFFFF;
    if (v < WIDE_W'(signed'(26'sh2000000))) return 26'sh2000000;
    return v[MIX_W-1:0];
  endfunction

endpackage

>>> rtl/core/rvb_ram.sv
// Generic single-port RAM with registered read data, read-before-write.
// No dependencies.
`timescale 1ns / 1ps
module rvb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rvb_ctrl.sv
// Sequencing state machine for the reverb unit: clear pass, comb and allpass loops, mix and clip.
// Depends on rvb_pkg.
`timescale 1ns / 1ps
module rvb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rvb_pkg::dp_sts_t    sts_i,
  output rvb_pkg::dp_cmd_t    cmd_o
);

  rvb_pkg::ctl_state_e               state_q, state_d;
  logic [rvb_pkg::UNIT_W-1:0]        unit_q, unit_d;
  logic                              comb_last;
  logic                              ap_last;

  assign comb_last = (unit_q == rvb_pkg::UNIT_W'(rvb_pkg::NUM_COMBS - 1));
  assign ap_last   = (unit_q == rvb_pkg::UNIT_W'(rvb_pkg::NUM_ALLPASS - 1));

  always_comb begin
    state_d = state_q;
    unit_d  = unit_q;
    unique case (state_q)
      rvb_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = rvb_pkg::ST_IDLE;
      end
      rvb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rvb_pkg::ST_COMB_RD;
      end
      rvb_pkg::ST_COMB_RD:  state_d = rvb_pkg::ST_COMB_MUL;
      rvb_pkg::ST_COMB_MUL: state_d = rvb_pkg::ST_COMB_LP;
      rvb_pkg::ST_COMB_LP:  state_d = rvb_pkg::ST_COMB_FB;
      rvb_pkg::ST_COMB_FB:  state_d = rvb_pkg::ST_COMB_WR;
      rvb_pkg::ST_COMB_WR: begin
        if (comb_last) begin
          state_d = rvb_pkg::ST_SUM;
          unit_d  = '0;
        end else begin
          state_d = rvb_pkg::ST_COMB_RD;
          unit_d  = unit_q + 1'b1;
        end
      end
      rvb_pkg::ST_SUM:    state_d = rvb_pkg::ST_AP_RD;
      rvb_pkg::ST_AP_RD:  state_d = rvb_pkg::ST_AP_UPD;
      rvb_pkg::ST_AP_UPD: begin
        if (ap_last) begin
          state_d = rvb_pkg::ST_MIX_MUL;
          unit_d  = '0;
        end else begin
          state_d = rvb_pkg::ST_AP_RD;
          unit_d  = unit_q + 1'b1;
        end
      end
      rvb_pkg::ST_MIX_MUL: state_d = rvb_pkg::ST_MIX_SUM;
      rvb_pkg::ST_MIX_SUM: state_d = rvb_pkg::ST_TAB0;
      rvb_pkg::ST_TAB0:    state_d = rvb_pkg::ST_TAB1;
      rvb_pkg::ST_TAB1:    state_d = rvb_pkg::ST_INTERP;
      rvb_pkg::ST_INTERP:  state_d = rvb_pkg::ST_EMIT;
      rvb_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = rvb_pkg::ST_IDLE;
      end
      default: state_d = rvb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.unit = unit_q;
    cmd_o.op   = rvb_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      rvb_pkg::ST_CLEAR: cmd_o.op = rvb_pkg::OP_CLEAR;
      rvb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = rvb_pkg::OP_LOAD;
      end
      rvb_pkg::ST_COMB_RD:  cmd_o.op = rvb_pkg::OP_COMB_RD;
      rvb_pkg::ST_COMB_MUL: cmd_o.op = rvb_pkg::OP_COMB_MUL;
      rvb_pkg::ST_COMB_LP:  cmd_o.op = rvb_pkg::OP_COMB_LP;
      rvb_pkg::ST_COMB_FB:  cmd_o.op = rvb_pkg::OP_COMB_FB;
      rvb_pkg::ST_COMB_WR:  cmd_o.op = rvb_pkg::OP_COMB_WR;
      rvb_pkg::ST_SUM:      cmd_o.op = rvb_pkg::OP_SUM;
      rvb_pkg::ST_AP_RD:    cmd_o.op = rvb_pkg::OP_AP_RD;
      rvb_pkg::ST_AP_UPD:   cmd_o.op = rvb_pkg::OP_AP_UPD;
      rvb_pkg::ST_MIX_MUL:  cmd_o.op = rvb_pkg::OP_MIX_MUL;
      rvb_pkg::ST_MIX_SUM:  cmd_o.op = rvb_pkg::OP_MIX_SUM;
      rvb_pkg::ST_TAB0:     cmd_o.op = rvb_pkg::OP_TAB0;
      rvb_pkg::ST_TAB1:     cmd_o.op = rvb_pkg::OP_TAB1;
      rvb_pkg::ST_INTERP:   cmd_o.op = rvb_pkg::OP_INTERP;
      rvb_pkg::ST_EMIT: begin
        if (sts_i.out_free) cmd_o.op = rvb_pkg::OP_EMIT;
      end
      default: cmd_o.op = rvb_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvb_pkg::ST_CLEAR;
      unit_q  <= '0;
    end else begin
      state_q <= state_d;
      unit_q  <= unit_d;
    end
  end

  // Each loop starts from the first unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rvb_pkg::ST_SUM) |-> (unit_q == '0))
    else $error("allpass loop does not start at unit zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rvb_pkg::ST_IDLE) |-> (unit_q == '0))
    else $error("comb loop does not start at unit zero");

  // The mix only follows the last allpass stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rvb_pkg::ST_MIX_MUL) |-> ($past(state_q) == rvb_pkg::ST_AP_UPD))
    else $error("mix entered without finishing the allpass chain");

endmodule

>>> rtl/core/rvb_datapath.sv
// Datapath of the reverb unit: delay memories, lowpass state, positions, arithmetic lanes,
// configuration registers and the output register. Depends on rvb_pkg and rvb_ram.
`timescale 1ns / 1ps
module rvb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rvb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rvb_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [rvb_pkg::DATA_W-1:0]          in_data_i,
  input  rvb_pkg::dp_cmd_t                    cmd_i,
  output rvb_pkg::dp_sts_t                    sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rvb_pkg::DATA_W-1:0]          out_data_o
);

  localparam int SW = rvb_pkg::SAMPLE_W;
  localparam int PW = rvb_pkg::PROD_W;
  localparam int WW = rvb_pkg::WIDE_W;

  logic [14:0] fb_q;
  logic [14:0] damp_q;
  logic [15:0] dry_q;
  logic [15:0] wet_q;

  logic [rvb_pkg::CLR_AW-1:0]   clr_cnt_q;
  logic [rvb_pkg::COMB_PW-1:0]  comb_pos_q [rvb_pkg::NUM_COMBS];
  logic [rvb_pkg::AP_PW-1:0]    ap_pos_q   [rvb_pkg::NUM_ALLPASS];
  logic [rvb_pkg::COMB_IW-1:0]  ci;
  logic [rvb_pkg::AP_IW-1:0]    ai;
  logic [rvb_pkg::COMB_PW:0]    comb_next;
  logic [rvb_pkg::AP_PW:0]      ap_next;

  logic signed [SW-1:0]                x_q      [2];
  logic signed [SW-1:0]                y_q      [2];
  logic signed [SW-1:0]                lp_q     [2][rvb_pkg::NUM_COMBS];
  logic signed [rvb_pkg::SUM_W-1:0]    sum_q    [2];
  logic signed [SW-1:0]                a_q      [2];
  logic signed [PW-1:0]                pa_q     [2];
  logic signed [PW-1:0]                pb_q     [2];
  logic signed [rvb_pkg::MIX_W-1:0]    m_q      [2];
  logic                                neg_q    [2];
  logic [rvb_pkg::TANH_IW-1:0]         idx_q    [2];
  logic [rvb_pkg::FRAC_W-1:0]          frac_q   [2];
  logic [SW-1:0]                       t0_q     [2];
  logic [SW-1:0]                       t1_q     [2];
  logic signed [rvb_pkg::INTERP_W-1:0] ip_q     [2];
  logic [rvb_pkg::DATA_W-1:0]          out_q;
  logic                                out_valid_q;

  logic signed [SW-1:0]              comb_w   [2];
  logic signed [SW-1:0]              ap_v     [2];
  logic signed [SW-1:0]              ap_a     [2];
  logic signed [SW-1:0]              y_rd     [2];
  logic [rvb_pkg::MIX_W-1:0]         mag      [2];
  logic [SW-1:0]                     t_val    [2];
  logic [SW-1:0]                     res      [2];
  logic [15:0]                       damp_c;

  logic                              comb_we, ap_we;
  logic [rvb_pkg::COMB_AW-1:0]       comb_addr;
  logic [rvb_pkg::AP_AW-1:0]         ap_addr;
  logic [rvb_pkg::DATA_W-1:0]        comb_wdata, ap_wdata, comb_rdata, ap_rdata;
  logic                              clearing;

  assign ci       = cmd_i.unit[rvb_pkg::COMB_IW-1:0];
  assign ai       = cmd_i.unit[rvb_pkg::AP_IW-1:0];
  assign clearing = (cmd_i.op == rvb_pkg::OP_CLEAR);
  assign damp_c   = 16'd32768 - {1'b0, damp_q};

  assign comb_next = {1'b0, comb_pos_q[ci]} + 1'b1;
  assign ap_next   = {1'b0, ap_pos_q[ai]} + 1'b1;

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      y_rd[ch]   = $signed(comb_rdata[ch*SW +: SW]);
      comb_w[ch] = rvb_pkg::sat24(WW'(x_q[ch]) + WW'(pb_q[ch] >>> 15));
      ap_v[ch]   = rvb_pkg::sat24(WW'(a_q[ch]) - WW'($signed(ap_rdata[ch*SW +: SW]) >>> 1));
      ap_a[ch]   = rvb_pkg::sat24(WW'($signed(ap_rdata[ch*SW +: SW])) + WW'(ap_v[ch] >>> 1));
      mag[ch]    = m_q[ch][rvb_pkg::MIX_W-1] ? rvb_pkg::MIX_W'(-m_q[ch]) : m_q[ch];
      t_val[ch]  = SW'(WW'($signed({1'b0, t0_q[ch]})) + WW'(ip_q[ch] >>> rvb_pkg::FRAC_W));
      res[ch]    = neg_q[ch] ? SW'(-t_val[ch]) : t_val[ch];
    end
  end

  always_comb begin
    comb_we    = 1'b0;
    ap_we      = 1'b0;
    comb_addr  = rvb_pkg::COMB_AW'(ci) * rvb_pkg::COMB_AW'(rvb_pkg::COMB_DEPTH)
               + rvb_pkg::COMB_AW'(comb_pos_q[ci]);
    ap_addr    = rvb_pkg::AP_AW'(ai) * rvb_pkg::AP_AW'(rvb_pkg::ALLPASS_DEPTH)
               + rvb_pkg::AP_AW'(ap_pos_q[ai]);
    comb_wdata = {comb_w[1], comb_w[0]};
    ap_wdata   = {ap_v[1], ap_v[0]};
    if (clearing) begin
      comb_we    = 1'b1;
      ap_we      = 1'b1;
      comb_addr  = clr_cnt_q[rvb_pkg::COMB_AW-1:0];
      ap_addr    = clr_cnt_q[rvb_pkg::AP_AW-1:0];
      comb_wdata = '0;
      ap_wdata   = '0;
    end else if (cmd_i.op == rvb_pkg::OP_COMB_WR) begin
      comb_we = 1'b1;
    end else if (cmd_i.op == rvb_pkg::OP_AP_UPD) begin
      ap_we = 1'b1;
    end
  end

  rvb_ram #(
    .WIDTH(rvb_pkg::DATA_W),
    .DEPTH(rvb_pkg::NUM_COMBS * rvb_pkg::COMB_DEPTH)
  ) u_comb_ram (
    .clk_i  (clk_i),
    .we_i   (comb_we),
    .addr_i (comb_addr),
    .wdata_i(comb_wdata),
    .rdata_o(comb_rdata)
  );

  rvb_ram #(
    .WIDTH(rvb_pkg::DATA_W),
    .DEPTH(rvb_pkg::NUM_ALLPASS * rvb_pkg::ALLPASS_DEPTH)
  ) u_ap_ram (
    .clk_i  (clk_i),
    .we_i   (ap_we),
    .addr_i (ap_addr),
    .wdata_i(ap_wdata),
    .rdata_o(ap_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= rvb_pkg::FEEDBACK_RESET;
      damp_q <= rvb_pkg::DAMPING_RESET;
      dry_q  <= rvb_pkg::DRY_RESET;
      wet_q  <= rvb_pkg::WET_RESET;
    end else if (cfg_we_i) begin
      unique case (rvb_pkg::cfg_reg_e'(cfg_idx_i))
        rvb_pkg::CFG_FEEDBACK: fb_q   <= cfg_wdata_i[14:0];
        rvb_pkg::CFG_DAMPING:  damp_q <= cfg_wdata_i[14:0];
        rvb_pkg::CFG_DRY:      dry_q  <= cfg_wdata_i;
        rvb_pkg::CFG_WET:      wet_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < rvb_pkg::NUM_COMBS; k++) begin
        comb_pos_q[k] <= '0;
        lp_q[0][k]    <= '0;
        lp_q[1][k]    <= '0;
      end
      for (int k = 0; k < rvb_pkg::NUM_ALLPASS; k++) begin
        ap_pos_q[k] <= '0;
      end
    end else begin
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == rvb_pkg::OP_EMIT) out_valid_q <= 1'b1;
      if (cmd_i.op == rvb_pkg::OP_COMB_LP) begin
        for (int ch = 0; ch < 2; ch++) begin
          lp_q[ch][ci] <= SW'((pa_q[ch] + pb_q[ch]) >>> 15);
        end
      end
      if (cmd_i.op == rvb_pkg::OP_COMB_WR) begin
        comb_pos_q[ci] <= (comb_next >= rvb_pkg::comb_len(int'(ci))) ? '0
                        : comb_next[rvb_pkg::COMB_PW-1:0];
      end
      if (cmd_i.op == rvb_pkg::OP_AP_UPD) begin
        ap_pos_q[ai] <= (ap_next >= rvb_pkg::ap_len(int'(ai))) ? '0
                      : ap_next[rvb_pkg::AP_PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 2; ch++) begin
      case (cmd_i.op)
        rvb_pkg::OP_LOAD: begin
          x_q[ch]   <= $signed(in_data_i[ch*SW +: SW]);
          sum_q[ch] <= '0;
        end
        rvb_pkg::OP_COMB_MUL: begin
          y_q[ch]  <= y_rd[ch];
          pa_q[ch] <= PW'(y_rd[ch]) * PW'($signed({1'b0, damp_c}));
          pb_q[ch] <= PW'(lp_q[ch][ci]) * PW'($signed({1'b0, damp_q}));
        end
        rvb_pkg::OP_COMB_LP: begin
          sum_q[ch] <= sum_q[ch] + rvb_pkg::SUM_W'(y_q[ch]);
        end
        rvb_pkg::OP_COMB_FB: begin
          pb_q[ch] <= PW'(lp_q[ch][ci]) * PW'($signed({1'b0, fb_q}));
        end
        rvb_pkg::OP_SUM: begin
          a_q[ch] <= rvb_pkg::sat24((WW'(sum_q[ch]) + (WW'(sum_q[ch]) <<< 1))
                                    >>> rvb_pkg::SUM_SHIFT);
        end
        rvb_pkg::OP_AP_UPD: begin
          a_q[ch] <= ap_a[ch];
        end
        rvb_pkg::OP_MIX_MUL: begin
          pa_q[ch] <= PW'(x_q[ch]) * PW'($signed({1'b0, dry_q}));
          pb_q[ch] <= PW'(a_q[ch]) * PW'($signed({1'b0, wet_q}));
        end
        rvb_pkg::OP_MIX_SUM: begin
          m_q[ch] <= rvb_pkg::sat_mix(WW'(pa_q[ch] + pb_q[ch]) >>> 15);
        end
        rvb_pkg::OP_TAB0: begin
          neg_q[ch]  <= m_q[ch][rvb_pkg::MIX_W-1];
          idx_q[ch]  <= mag[ch][rvb_pkg::MIX_W-1 -: rvb_pkg::TANH_IW];
          frac_q[ch] <= mag[ch][rvb_pkg::FRAC_W-1:0];
          t0_q[ch]   <= rvb_pkg::TANH_TAB[mag[ch][rvb_pkg::MIX_W-1 -: rvb_pkg::TANH_IW]];
        end
        rvb_pkg::OP_TAB1: begin
          t1_q[ch] <= (idx_q[ch] == rvb_pkg::TANH_IW'(rvb_pkg::TANH_ENTRIES))
                    ? rvb_pkg::TANH_TAB[idx_q[ch]]
                    : rvb_pkg::TANH_TAB[idx_q[ch] + 1'b1];
        end
        rvb_pkg::OP_INTERP: begin
          ip_q[ch] <= rvb_pkg::INTERP_W'($signed({1'b0, t1_q[ch]}) - $signed({1'b0, t0_q[ch]}))
                    * rvb_pkg::INTERP_W'($signed({1'b0, frac_q[ch]}));
        end
        default: ;
      endcase
    end
    if (cmd_i.op == rvb_pkg::OP_EMIT) out_q <= {res[1], res[0]};
  end

  assign sts_o.clr_last = &clr_cnt_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  for (genvar g = 0; g < rvb_pkg::NUM_COMBS; g++) begin : g_pos_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      ({1'b0, comb_pos_q[g]} < rvb_pkg::comb_len(g)))
      else $error("comb position beyond its delay length");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(cmd_i.op) == rvb_pkg::OP_EMIT))
    else $error("output word appeared without an emit step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_cnt_q != '0) |-> ($past(cmd_i.op) == rvb_pkg::OP_CLEAR))
    else $error("clear counter moved outside the clearing pass");

endmodule

>>> rtl/core/stereo_comb_allpass_reverb_unit.sv
// An accepted word passes the comb loop, sum, allpass loop, mix, tanh lookup, interpolation and
// emit steps; the combs share one lane, as do the allpasses. A new word is taken only after the
// previous one is emitted. After reset a clearing pass zeroes both delay memories, and no word
// is taken then. Reset returns the configuration registers to their defaults and clears lowpass
// state and positions. Depends on rvb_pkg, rvb_ctrl, rvb_datapath and rvb_ram.
`timescale 1ns / 1ps
module stereo_comb_allpass_reverb_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rvb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rvb_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rvb_pkg::DATA_W-1:0]         s_axis_tdata,  // left_in, right_in
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rvb_pkg::DATA_W-1:0]         m_axis_tdata   // left_out, right_out
);

  rvb_pkg::dp_cmd_t cmd;
  rvb_pkg::dp_sts_t sts;

  rvb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rvb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
